### sv/t2k_pkg.sv
// Shared constants for the thermistor sample to kelvin converter.
`default_nettype none
package t2k_pkg;
  localparam int SAMPLE_W = 10;
  localparam int REF_W = 20;
  localparam int T0_W = 10;
  localparam int BETA_W = 14;
  localparam int TEMP_W = 12;
  localparam int STAT_W = 2;
  localparam int IDX_W = 2;
  localparam int FRAC_W = 16;
  localparam int MANT_W = 32;
  localparam int RSCALE_W = 8;
  localparam int RQ_W = 40;
  localparam int LOG_NS = $clog2(RQ_W);
  localparam int LN_W = LOG_NS + FRAC_W;
  localparam int LOG_LAT = LOG_NS + FRAC_W + 1;
  localparam int BT_NW = BETA_W + FRAC_W;
  localparam int DEN_W = BT_NW + 1;

  localparam logic [RQ_W-1:0] RQ_MAX = '1;
  localparam logic [MANT_W-1:0] LN2_Q32 = 32'd2977044472;
  localparam logic [TEMP_W-1:0] TEMP_MAX = 12'd4095;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_RAIL = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  localparam logic [IDX_W-1:0] CFG_REF = 2'd0;
  localparam logic [IDX_W-1:0] CFG_NOM = 2'd1;
  localparam logic [IDX_W-1:0] CFG_T0 = 2'd2;
  localparam logic [IDX_W-1:0] CFG_BETA = 2'd3;
endpackage
`default_nettype wire

### sv/thermistor_adc_to_kelvin.sv
// Top level of the thermistor sample to kelvin converter.
// The converter takes one sample in every clock cycle and never stalls; busy stays low.
// Each result appears on temperature_kelvin and status for one cycle with done high.
// A sample passes 2 + (ADC_BITS + 28) + 1 + 23 + 1 + 30 + 1 register stages (96 for
// ADC_BITS of 10). Most of them are the divider cell rows for the resistance and the
// final quotient, plus the 23 stages of the logarithm unit. The receiver cannot stall,
// so it must take every result in the cycle it is shown. The user must write registers
// over the cfg channel only while no samples are in flight; the block does not enforce
// this.
`default_nettype none
module thermistor_adc_to_kelvin #(
  parameter int ADC_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [t2k_pkg::SAMPLE_W-1:0]  adc_sample,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [t2k_pkg::IDX_W-1:0]     cfg_index,
  input  logic [t2k_pkg::REF_W-1:0]     cfg_data,
  output logic                          done,
  output logic [t2k_pkg::TEMP_W-1:0]    temperature_kelvin,
  output logic [t2k_pkg::STAT_W-1:0]    status
);
  import t2k_pkg::*;

  localparam int NWA = REF_W + ADC_BITS + RSCALE_W;
  localparam int QXW = (NWA > RQ_W) ? NWA : RQ_W;
  localparam int D1 = NWA + 1 + LOG_LAT;
  localparam int D2 = BT_NW;
  localparam logic [ADC_BITS-1:0] FS = '1;

  logic [REF_W-1:0]  reference_ohms;
  logic [REF_W-1:0]  nominal_ohms;
  logic [T0_W-1:0]   nominal_kelvin;
  logic [BETA_W-1:0] beta_kelvin;

  logic [15:0]             samp16;
  logic [ADC_BITS-1:0]     s_in;
  logic                    v0;
  logic [ADC_BITS-1:0]     s0;
  logic                    v1;
  logic                    rail1;
  logic [REF_W+ADC_BITS-1:0] prod1;
  logic [ADC_BITS-1:0]     dd1;
  logic [NWA-1:0]          quo_a;
  logic [QXW-1:0]          quo_x;
  logic [RQ_W-1:0]         rq;
  logic [LN_W-1:0]         ln_a;
  logic [LN_W-1:0]         ln_r;
  logic [RQ_W-1:0]         r0_x;
  logic [T0_W-1:0]         t0;
  logic [BT_NW-1:0]        beta_q16;
  logic [BT_NW-1:0]        bt;
  logic [D1-1:0]           v_d1;
  logic [D1-1:0]           rail_d1;
  logic signed [31:0]      den;
  logic                    vc;
  logic                    railc;
  logic                    npc;
  logic [DEN_W-1:0]        denc;
  logic [D2-1:0]           v_d2;
  logic [D2-1:0]           rail_d2;
  logic [D2-1:0]           np_d2;
  logic [BT_NW-1:0]        quo_q;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_ohms <= 20'd10000;
      nominal_ohms <= 20'd10000;
      nominal_kelvin <= 10'd298;
      beta_kelvin <= 14'd3950;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REF:  reference_ohms <= cfg_data;
        CFG_NOM:  nominal_ohms <= cfg_data;
        CFG_T0:   nominal_kelvin <= cfg_data[T0_W-1:0];
        CFG_BETA: beta_kelvin <= cfg_data[BETA_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    samp16 = 16'(adc_sample);
    s_in = samp16[ADC_BITS-1:0];
    t0 = (nominal_kelvin == '0) ? T0_W'(1) : nominal_kelvin;
    beta_q16 = {beta_kelvin, {FRAC_W{1'b0}}};
    r0_x = RQ_W'({nominal_ohms, {RSCALE_W{1'b0}}});
    quo_x = QXW'(quo_a);
    den = $signed(32'(ln_a)) - $signed(32'(ln_r)) + $signed(32'(bt));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v_d1 <= '0;
      vc <= 1'b0;
      v_d2 <= '0;
      done <= 1'b0;
    end else begin
      v0 <= start && !busy;
      v1 <= v0;
      v_d1 <= {v_d1[D1-2:0], v1};
      vc <= v_d1[D1-1];
      v_d2 <= {v_d2[D2-2:0], vc};
      done <= v_d2[D2-1];
    end
  end

  always_ff @(posedge clk) begin
    s0 <= s_in;
    rail1 <= (s0 == '0) || (s0 == FS);
    prod1 <= reference_ohms * s0;
    dd1 <= FS - s0;
    rq <= (quo_x > QXW'(RQ_MAX)) ? RQ_MAX : quo_x[RQ_W-1:0];
    rail_d1 <= {rail_d1[D1-2:0], rail1};
    railc <= rail_d1[D1-1];
    npc <= den[31] || (den == 32'sd0);
    denc <= den[DEN_W-1:0];
    rail_d2 <= {rail_d2[D2-2:0], railc};
    np_d2 <= {np_d2[D2-2:0], npc};
    if (rail_d2[D2-1]) begin
      temperature_kelvin <= '0;
      status <= ST_RAIL;
    end else if (np_d2[D2-1] || (quo_q > BT_NW'(TEMP_MAX))) begin
      temperature_kelvin <= TEMP_MAX;
      status <= ST_RANGE;
    end else begin
      temperature_kelvin <= quo_q[TEMP_W-1:0];
      status <= ST_OK;
    end
  end

  t2k_div #(.NW(NWA), .DW(ADC_BITS)) u_div_r (
    .clk      (clk),
    .dividend ({prod1, {RSCALE_W{1'b0}}}),
    .divisor  (dd1),
    .quotient (quo_a)
  );

  t2k_log u_log_r (
    .clk (clk),
    .x   (rq),
    .ln  (ln_a)
  );

  t2k_log u_log_nom (
    .clk (clk),
    .x   (r0_x),
    .ln  (ln_r)
  );

  t2k_div #(.NW(BT_NW), .DW(T0_W)) u_div_bt (
    .clk      (clk),
    .dividend (beta_q16),
    .divisor  (t0),
    .quotient (bt)
  );

  t2k_div #(.NW(BT_NW), .DW(DEN_W)) u_div_t (
    .clk      (clk),
    .dividend (beta_q16),
    .divisor  (denc),
    .quotient (quo_q)
  );
endmodule
`default_nettype wire

### sv/t2k_div_cell.sv
// One restoring division step that produces one quotient bit per cycle.
`default_nettype none
module t2k_div_cell #(
  parameter int NW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic [DW-1:0] rem_in,
  input  logic [NW-1:0] work_in,
  input  logic [DW-1:0] dvs_in,
  output logic [DW-1:0] rem_out,
  output logic [NW-1:0] work_out,
  output logic [DW-1:0] dvs_out
);
  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        qbit;

  always_comb begin
    trial = {rem_in, work_in[NW-1]};
    diff = trial - {1'b0, dvs_in};
    qbit = (trial >= {1'b0, dvs_in});
  end

  always_ff @(posedge clk) begin
    rem_out <= qbit ? diff[DW-1:0] : trial[DW-1:0];
    work_out <= {work_in[NW-2:0], qbit};
    dvs_out <= dvs_in;
  end
endmodule
`default_nettype wire

### sv/t2k_div.sv
// Pipelined unsigned divider built as a row of restoring division cells.
`default_nettype none
module t2k_div #(
  parameter int NW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient
);
  logic [DW-1:0] rem [0:NW];
  logic [NW-1:0] work [0:NW];
  logic [DW-1:0] dvs [0:NW];

  assign rem[0] = '0;
  assign work[0] = dividend;
  assign dvs[0] = divisor;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    t2k_div_cell #(.NW(NW), .DW(DW)) u_cell (
      .clk      (clk),
      .rem_in   (rem[i]),
      .work_in  (work[i]),
      .dvs_in   (dvs[i]),
      .rem_out  (rem[i+1]),
      .work_out (work[i+1]),
      .dvs_out  (dvs[i+1])
    );
  end

  assign quotient = work[NW];
endmodule
`default_nettype wire

### sv/t2k_log.sv
// Pipelined natural logarithm in Q6.16 by normalization and repeated squaring.
`default_nettype none
module t2k_log (
  input  logic                     clk,
  input  logic [t2k_pkg::RQ_W-1:0] x,
  output logic [t2k_pkg::LN_W-1:0] ln
);
  import t2k_pkg::*;

  logic [RQ_W-1:0]   nx [0:LOG_NS];
  logic [LOG_NS-1:0] lz [0:LOG_NS];
  logic [MANT_W-1:0] m [0:FRAC_W];
  logic [FRAC_W-1:0] fr [0:FRAC_W];
  logic [LOG_NS-1:0] pp [0:FRAC_W];
  logic [LN_W-1:0]   lg;
  logic [LN_W+MANT_W-1:0] lprod;

  assign nx[0] = (x == '0) ? RQ_W'(1) : x;
  assign lz[0] = '0;

  for (genvar k = 0; k < LOG_NS; k++) begin : g_norm
    localparam int SH = 1 << (LOG_NS - 1 - k);
    always_ff @(posedge clk) begin
      if (nx[k][RQ_W-1 -: SH] == '0) begin
        nx[k+1] <= nx[k] << SH;
        lz[k+1] <= lz[k] + LOG_NS'(SH);
      end else begin
        nx[k+1] <= nx[k];
        lz[k+1] <= lz[k];
      end
    end
  end

  assign m[0] = nx[LOG_NS][RQ_W-1 -: MANT_W];
  assign fr[0] = '0;
  assign pp[0] = LOG_NS'(RQ_W - 1) - lz[LOG_NS];

  for (genvar j = 0; j < FRAC_W; j++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;
    always_comb begin
      sq = m[j] * m[j];
      t = sq[2*MANT_W-1:MANT_W-1];
    end
    always_ff @(posedge clk) begin
      m[j+1] <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
      fr[j+1] <= {fr[j][FRAC_W-2:0], t[MANT_W]};
      pp[j+1] <= pp[j];
    end
  end

  always_comb begin
    lg = {pp[FRAC_W], fr[FRAC_W]};
    lprod = lg * LN2_Q32;
  end

  always_ff @(posedge clk) begin
    ln <= lprod[LN_W+MANT_W-1:MANT_W];
  end
endmodule
`default_nettype wire
